// File: sv/sync_event_pdo_scheduler_defines.svh
// ----------------------------------------------------------------------------
// sync_event_pdo_scheduler_defines
// assertion macros for the sync event pdo scheduler
// ----------------------------------------------------------------------------
`ifndef SYNC_EVENT_PDO_SCHEDULER_DEFINES_SVH
`define SYNC_EVENT_PDO_SCHEDULER_DEFINES_SVH

// concurrent check on clk, off during reset
`define SESCHED_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that holds in reset too
`define SESCHED_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sesched_pkg.sv
// ----------------------------------------------------------------------------
// sesched_pkg
// types, codes and constants of the sync event pdo scheduler
// ----------------------------------------------------------------------------
`default_nettype none
package sesched_pkg;

  localparam int DEF_TX_SLOTS = 8;
  localparam int DEF_RX_SLOTS = 8;
  localparam int MAX_RESULTS  = 16;
  localparam int US_PER_TICK  = 100;
  localparam int ID_W         = 29;
  localparam int PRODUCER_BIT = 30;

  localparam logic [2:0] KIND_FRAME   = 3'd0;
  localparam logic [2:0] KIND_ADD     = 3'd1;
  localparam logic [2:0] KIND_REMOVE  = 3'd2;
  localparam logic [2:0] KIND_RESTART = 3'd3;
  localparam logic [2:0] KIND_TICK    = 3'd4;

  localparam logic [1:0] REG_SYNC_COB_ID  = 2'd0;
  localparam logic [1:0] REG_CYCLE_PERIOD = 2'd1;
  localparam logic [1:0] REG_SYNC_ALLOWED = 2'd2;

  localparam logic [1:0] ACT_TX   = 2'd0;
  localparam logic [1:0] ACT_RX   = 2'd1;
  localparam logic [1:0] ACT_SYNC = 2'd2;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_SYNC    = 4'd1;
  localparam logic [3:0] OP_FRAME   = 4'd2;
  localparam logic [3:0] OP_ADD_TX  = 4'd3;
  localparam logic [3:0] OP_ADD_RX  = 4'd4;
  localparam logic [3:0] OP_REM_TX  = 4'd5;
  localparam logic [3:0] OP_REM_RX  = 4'd6;
  localparam logic [3:0] OP_RESTART = 4'd7;
  localparam logic [3:0] OP_TICK    = 4'd8;

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] frame_id;
    logic [3:0]      frame_dlc;
    logic [63:0]     frame_data;
    logic            slot_dir;
    logic [2:0]      slot;
    logic [7:0]      tx_type;
  } item_t;

  typedef struct packed {
    logic [1:0]      action;
    logic [2:0]      out_slot;
    logic [ID_W-1:0] out_identifier;
    logic [63:0]     out_data;
    logic [3:0]      out_dlc;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [3:0]      op;
    logic [ID_W-1:0] frame_id;
    logic [3:0]      frame_dlc;
    logic [63:0]     frame_data;
    logic [2:0]      slot;
    logic [7:0]      tx_type;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/sesched_front.sv
// ----------------------------------------------------------------------------
// sesched_front
// classifies input items into commands and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module sesched_front import sesched_pkg::*; #(
  parameter int TX_SLOTS = DEF_TX_SLOTS,
  parameter int RX_SLOTS = DEF_RX_SLOTS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire item_t           item,
  input  wire logic [ID_W-1:0] sync_id,
  output logic                 busy,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  wire logic            cmd_ready
);

  cmd_t       q0, q1, new_cmd;
  logic [1:0] cnt;
  logic       push, pop;
  logic       tx_ok, rx_ok;

  assign tx_ok = 32'(item.slot) < TX_SLOTS;
  assign rx_ok = 32'(item.slot) < RX_SLOTS;

  always_comb begin
    new_cmd            = '0;
    new_cmd.frame_id   = item.frame_id;
    new_cmd.frame_dlc  = item.frame_dlc;
    new_cmd.frame_data = item.frame_data;
    new_cmd.slot       = item.slot;
    new_cmd.tx_type    = item.tx_type;
    case (item.kind)
      KIND_FRAME: begin
        new_cmd.op = (item.frame_id == sync_id) ? OP_SYNC : OP_FRAME;
      end
      KIND_ADD: begin
        if (item.slot_dir) new_cmd.op = rx_ok ? OP_ADD_RX : OP_NONE;
        else new_cmd.op = tx_ok ? OP_ADD_TX : OP_NONE;
      end
      KIND_REMOVE: begin
        if (item.slot_dir) new_cmd.op = rx_ok ? OP_REM_RX : OP_NONE;
        else new_cmd.op = tx_ok ? OP_REM_TX : OP_NONE;
      end
      KIND_RESTART: new_cmd.op = OP_RESTART;
      KIND_TICK:    new_cmd.op = OP_TICK;
      default:      new_cmd.op = OP_NONE;
    endcase
  end

  assign busy      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q0;
  assign push      = start && !busy && (new_cmd.op != OP_NONE);
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (cnt == 2'd1) begin
          q0 <= new_cmd;
        end else begin
          q0 <= q1;
          q1 <= new_cmd;
        end
      end
      2'b10: begin
        if (cnt == 2'd0) q0 <= new_cmd;
        else q1 <= new_cmd;
      end
      2'b01:   q0 <= q1;
      default: q0 <= q0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/sesched_back.sv
// ----------------------------------------------------------------------------
// sesched_back
// slot tables, sync walk, frame store and sync producer
// ----------------------------------------------------------------------------
`default_nettype none
module sesched_back import sesched_pkg::*; #(
  parameter int TX_SLOTS = DEF_TX_SLOTS,
  parameter int RX_SLOTS = DEF_RX_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_ready,
  input  wire logic [31:0] sync_cob_id,
  input  wire logic [31:0] cycle_period_us,
  input  wire logic        sync_allowed,
  input  wire logic        prod_clear,
  output logic             result_valid,
  output result_t          result
);

  localparam int TXW = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
  localparam int RXW = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
  localparam int NW  = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INC   = 3'd1;
  localparam logic [2:0] S_TXW   = 3'd2;
  localparam logic [2:0] S_RXW   = 3'd3;
  localparam logic [2:0] S_MATCH = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]      state;
  cmd_t            cur;
  logic [TXW-1:0]  tx_idx;
  logic [RXW-1:0]  rx_idx;
  logic [NW-1:0]   n_emit;
  logic            held_v;
  result_t         held;
  logic [33:0]     us_acc;

  logic            tx_active [TX_SLOTS];
  logic [7:0]      tx_type   [TX_SLOTS];
  logic [7:0]      tx_count  [TX_SLOTS];
  logic            rx_active [RX_SLOTS];
  logic [ID_W-1:0] rx_id     [RX_SLOTS];
  logic [63:0]     rx_data   [RX_SLOTS];
  logic [3:0]      rx_dlc    [RX_SLOTS];

  logic            emit_en;
  result_t         emit_res;
  logic            tx_hit;
  logic            prod_off;
  logic            prod_wrap;

  assign cmd_ready = (state == S_IDLE);
  assign tx_hit    = tx_active[tx_idx] &&
                     ((tx_type[tx_idx] == 8'd0) || (tx_count[tx_idx] == tx_type[tx_idx]));
  assign prod_off  = !sync_cob_id[PRODUCER_BIT] || (cycle_period_us < 32'(US_PER_TICK));
  // period reached when cycle < 100 * (count + 2)
  assign prod_wrap = {2'b00, cycle_period_us} < (us_acc + 34'(2 * US_PER_TICK));

  always_comb begin
    emit_res = '0;
    emit_en  = 1'b0;
    if (state == S_TXW) begin
      emit_en         = tx_hit;
      emit_res.action = ACT_TX;
      emit_res.out_slot = 3'(tx_idx);
    end else if (state == S_RXW) begin
      emit_en           = rx_active[rx_idx];
      emit_res.action   = ACT_RX;
      emit_res.out_slot = 3'(rx_idx);
      emit_res.out_data = rx_data[rx_idx];
      emit_res.out_dlc  = rx_dlc[rx_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tx_idx       <= '0;
      rx_idx       <= '0;
      n_emit       <= '0;
      held_v       <= 1'b0;
      result_valid <= 1'b0;
      us_acc       <= '0;
      for (int i = 0; i < TX_SLOTS; i++) begin
        tx_active[i] <= 1'b0;
        tx_type[i]   <= 8'd0;
        tx_count[i]  <= 8'd0;
      end
      for (int i = 0; i < RX_SLOTS; i++) begin
        rx_active[i] <= 1'b0;
        rx_id[i]     <= '0;
        rx_data[i]   <= '0;
        rx_dlc[i]    <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      if (prod_clear) us_acc <= '0;
      if (emit_en && (n_emit < NW'(MAX_RESULTS))) begin
        n_emit <= n_emit + NW'(1);
        held   <= emit_res;
        held_v <= 1'b1;
        if (held_v) begin
          result       <= held;
          result_valid <= 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur    <= cmd;
            tx_idx <= '0;
            rx_idx <= '0;
            n_emit <= '0;
            case (cmd.op)
              OP_SYNC:  state <= S_INC;
              OP_FRAME: state <= S_MATCH;
              OP_ADD_TX: begin
                tx_active[TXW'(cmd.slot)] <= 1'b1;
                tx_type[TXW'(cmd.slot)]   <= cmd.tx_type;
                tx_count[TXW'(cmd.slot)]  <= 8'd0;
              end
              OP_REM_TX: begin
                tx_active[TXW'(cmd.slot)] <= 1'b0;
                tx_type[TXW'(cmd.slot)]   <= 8'd0;
                tx_count[TXW'(cmd.slot)]  <= 8'd0;
              end
              OP_ADD_RX: begin
                rx_active[RXW'(cmd.slot)] <= 1'b1;
                rx_id[RXW'(cmd.slot)]     <= cmd.frame_id;
              end
              OP_REM_RX: rx_active[RXW'(cmd.slot)] <= 1'b0;
              OP_RESTART: begin
                for (int i = 0; i < TX_SLOTS; i++) begin
                  if (tx_active[i]) tx_count[i] <= 8'd0;
                end
              end
              OP_TICK: begin
                if (prod_off) begin
                  us_acc <= '0;
                end else if (prod_wrap) begin
                  us_acc <= '0;
                  if (sync_allowed) begin
                    held   <= '{action: ACT_SYNC, out_slot: 3'd0,
                                out_identifier: sync_cob_id[ID_W-1:0],
                                out_data: 64'd0, out_dlc: 4'd0, last: 1'b0};
                    held_v <= 1'b1;
                    state  <= S_FLUSH;
                  end
                end else begin
                  us_acc <= us_acc + 34'(US_PER_TICK);
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_INC: begin
          for (int i = 0; i < TX_SLOTS; i++) begin
            if (tx_active[i] && (tx_count[i] != 8'hff)) tx_count[i] <= tx_count[i] + 8'd1;
          end
          state <= S_TXW;
        end
        S_TXW: begin
          if (tx_hit && (tx_type[tx_idx] != 8'd0)) tx_count[tx_idx] <= 8'd0;
          if (32'(tx_idx) == TX_SLOTS - 1) state <= S_RXW;
          else tx_idx <= tx_idx + TXW'(1);
        end
        S_RXW: begin
          if (32'(rx_idx) == RX_SLOTS - 1) state <= S_FLUSH;
          else rx_idx <= rx_idx + RXW'(1);
        end
        S_MATCH: begin
          if (rx_active[rx_idx] && (rx_id[rx_idx] == cur.frame_id)) begin
            rx_data[rx_idx] <= cur.frame_data;
            rx_dlc[rx_idx]  <= cur.frame_dlc;
            state           <= S_IDLE;
          end else if (32'(rx_idx) == RX_SLOTS - 1) begin
            state <= S_IDLE;
          end else begin
            rx_idx <= rx_idx + RXW'(1);
          end
        end
        S_FLUSH: begin
          if (held_v) begin
            result       <= '{action: held.action, out_slot: held.out_slot,
                              out_identifier: held.out_identifier,
                              out_data: held.out_data, out_dlc: held.out_dlc,
                              last: 1'b1};
            result_valid <= 1'b1;
            held_v       <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/sync_event_pdo_scheduler.sv
// ----------------------------------------------------------------------------
// sync_event_pdo_scheduler
// sync driven pdo scheduler with a periodic sync producer
// ----------------------------------------------------------------------------
// back end: slot edits, restarts and quiet ticks finish in the idle state, a tick
//   that sends sync goes through the flush state, a sync frame walks the slots
//   one per cycle (transmit, then receive) and a data frame stops at the first match
// throughput: one item per back end run; a two entry queue takes items ahead
// results pass a one deep hold so the final one carries last; no stall
// reset: synchronous, clears the slot tables, state, valid flags, configuration and the producer count
`default_nettype none
module sync_event_pdo_scheduler import sesched_pkg::*; #(
  parameter int TX_SLOTS = DEF_TX_SLOTS,
  parameter int RX_SLOTS = DEF_RX_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire item_t       item,
  output logic             busy,
  output logic             result_valid,
  output result_t          result,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

`include "sync_event_pdo_scheduler_defines.svh"

  logic [31:0] sync_cob_id;
  logic [31:0] cycle_period_us;
  logic        sync_allowed;
  logic        prod_clear;
  logic        cmd_valid;
  logic        cmd_ready;
  cmd_t        cmd;
  logic        sync_out;
  logic        tx_out;

  assign prod_clear = cfg_write &&
                      ((cfg_index == REG_SYNC_COB_ID) || (cfg_index == REG_CYCLE_PERIOD));

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_cob_id     <= '0;
      cycle_period_us <= '0;
      sync_allowed    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SYNC_COB_ID:  sync_cob_id     <= cfg_data;
        REG_CYCLE_PERIOD: cycle_period_us <= cfg_data;
        REG_SYNC_ALLOWED: sync_allowed    <= cfg_data[0];
        default:          sync_allowed    <= sync_allowed;
      endcase
    end
  end

  sesched_front #(.TX_SLOTS(TX_SLOTS), .RX_SLOTS(RX_SLOTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .sync_id   (sync_cob_id[ID_W-1:0]),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  sesched_back #(.TX_SLOTS(TX_SLOTS), .RX_SLOTS(RX_SLOTS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_ready       (cmd_ready),
    .sync_cob_id     (sync_cob_id),
    .cycle_period_us (cycle_period_us),
    .sync_allowed    (sync_allowed),
    .prod_clear      (prod_clear),
    .result_valid    (result_valid),
    .result          (result)
  );

  assign sync_out = result_valid && (result.action == ACT_SYNC);
  assign tx_out   = result_valid && (result.action == ACT_TX);

  `SESCHED_CHECK(a_sync_single, sync_out |-> result.last, "sync frame result not last")
  `SESCHED_CHECK(a_sync_fields, sync_out |-> (result.out_data == 64'd0) && (result.out_slot == 3'd0), "sync frame carries slot data")
  `SESCHED_CHECK(a_tx_fields, tx_out |-> (result.out_identifier == '0) && (result.out_dlc == 4'd0), "transmit result carries frame fields")
  `SESCHED_CHECK_ALWAYS(a_reset_quiet, rst |=> !result_valid && !busy, "activity right after reset")

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the sync event pdo scheduler against a behavioral predictor: slot
// edits, received frames, sync walks and the periodic producer, under random
// start gaps, with register settings changed between phases while idle
// ----------------------------------------------------------------------------
module tb_top;
  import sesched_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTX = DEF_TX_SLOTS;
  localparam int NRX = DEF_RX_SLOTS;
  localparam logic [ID_W-1:0] SYNC_A = 29'h080;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t item = '0;
  logic busy;
  logic result_valid;
  result_t result;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_SYNC_COB_ID;
  logic [31:0] cfg_data = '0;

  sync_event_pdo_scheduler dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .result_valid(result_valid), .result(result), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] cob_id_q, period_us_q;
  logic allowed_q;
  logic tx_on [NTX];
  logic [7:0] tx_kind [NTX];
  logic [7:0] tx_cnt [NTX];
  logic rx_on [NRX];
  logic [ID_W-1:0] rx_id [NRX];
  logic [63:0] rx_data [NRX];
  logic [3:0] rx_dlc [NRX];
  logic [31:0] tick_cnt;

  item_t pending_items[$];
  result_t expected_results[$];
  int errors = 0;
  int idle_pct = 0;
  int quiet = 0;

  task automatic add_result(input logic [1:0] act, input int s, input logic [ID_W-1:0] id,
                            input logic [63:0] d, input logic [3:0] l, inout int n);
    result_t r;
    if (n < MAX_RESULTS) begin
      r = '{action: act, out_slot: 3'(s), out_identifier: id, out_data: d,
            out_dlc: l, last: 1'b0};
      expected_results.push_back(r);
      n++;
    end
  endtask

  task automatic predict_item(input item_t it);
    int n;
    int p;
    bit hit;
    n = 0;
    case (it.kind)
      KIND_FRAME: begin
        if (it.frame_id == cob_id_q[ID_W-1:0]) begin
          for (int i = 0; i < NTX; i++)
            if (tx_on[i] && tx_cnt[i] != 8'hff) tx_cnt[i]++;
          for (int i = 0; i < NTX; i++) begin
            if (tx_on[i]) begin
              if (tx_kind[i] == 0) add_result(ACT_TX, i, '0, '0, '0, n);
              else if (tx_cnt[i] == tx_kind[i]) begin
                add_result(ACT_TX, i, '0, '0, '0, n);
                tx_cnt[i] = 0;
              end
            end
          end
          for (int i = 0; i < NRX; i++)
            if (rx_on[i]) add_result(ACT_RX, i, '0, rx_data[i], rx_dlc[i], n);
        end else begin
          hit = 0;
          for (int i = 0; i < NRX; i++) begin
            if (!hit && rx_on[i] && rx_id[i] == it.frame_id) begin
              rx_data[i] = it.frame_data;
              rx_dlc[i] = it.frame_dlc;
              hit = 1;
            end
          end
        end
      end
      KIND_ADD: begin
        if (it.slot_dir == 0) begin
          tx_on[it.slot] = 1; tx_kind[it.slot] = it.tx_type; tx_cnt[it.slot] = 0;
        end else begin
          rx_on[it.slot] = 1; rx_id[it.slot] = it.frame_id;
        end
      end
      KIND_REMOVE: begin
        if (it.slot_dir == 0) begin
          tx_on[it.slot] = 0; tx_kind[it.slot] = 0; tx_cnt[it.slot] = 0;
        end else begin
          rx_on[it.slot] = 0;
        end
      end
      KIND_RESTART: begin
        for (int i = 0; i < NTX; i++) if (tx_on[i]) tx_cnt[i] = 0;
      end
      KIND_TICK: begin
        p = int'(period_us_q / US_PER_TICK);
        if (!cob_id_q[PRODUCER_BIT] || p == 0) tick_cnt = 0;
        else begin
          tick_cnt++;
          if (tick_cnt >= 32'(p)) begin
            tick_cnt = 0;
            if (allowed_q) add_result(ACT_SYNC, 0, cob_id_q[ID_W-1:0], '0, '0, n);
          end
        end
      end
      default: ;
    endcase
    if (n > 0) expected_results[$].last = 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) predict_item(item);
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        item <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", result);
        errors++;
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (e.action != result.action) begin
          $error("action exp %0d got %0d", e.action, result.action); errors++;
        end
        if (e.out_slot != result.out_slot) begin
          $error("out_slot exp %0d got %0d", e.out_slot, result.out_slot); errors++;
        end
        if (e.out_identifier != result.out_identifier) begin
          $error("out_identifier exp %h got %h", e.out_identifier, result.out_identifier);
          errors++;
        end
        if (e.out_data != result.out_data) begin
          $error("out_data exp %h got %h", e.out_data, result.out_data); errors++;
        end
        if (e.out_dlc != result.out_dlc) begin
          $error("out_dlc exp %0d got %0d", e.out_dlc, result.out_dlc); errors++;
        end
        if (e.last != result.last) begin
          $error("last exp %0d got %0d", e.last, result.last); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || rst ||
        (pending_items.size() == 0 && expected_results.size() == 0 && !start))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("[sync_event_pdo_scheduler] ERROR");
      $finish;
    end
  end

  function automatic item_t rand_item(input int sync_pct);
    item_t it;
    int r;
    it.kind = 3'($urandom_range(4));
    if ($urandom_range(40) == 0) it.kind = 3'($urandom_range(7, 5));
    it.frame_id = ($urandom_range(3) == 0) ? 29'($urandom) : 29'($urandom_range(3) + 1);
    it.frame_dlc = 4'($urandom);
    it.frame_data = {$urandom, $urandom};
    it.slot_dir = 1'($urandom);
    it.slot = 3'($urandom);
    r = $urandom_range(3);
    it.tx_type = (r == 0) ? 8'd0 : (r == 1) ? 8'($urandom) : 8'($urandom_range(4) + 1);
    if ($urandom_range(99) < sync_pct) begin
      it.kind = KIND_FRAME;
      it.frame_id = cob_id_q[ID_W-1:0];
    end
    return it;
  endfunction

  function automatic item_t mk(input logic [2:0] k, input logic [ID_W-1:0] id,
                               input logic dir, input logic [2:0] s, input logic [7:0] t,
                               input logic [3:0] l, input logic [63:0] d);
    item_t it;
    it = '{kind: k, frame_id: id, frame_dlc: l, frame_data: d, slot_dir: dir,
           slot: s, tx_type: t};
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (2 * (NTX + NRX) + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SYNC_COB_ID: begin cob_id_q = v; tick_cnt = 0; end
      REG_CYCLE_PERIOD: begin period_us_q = v; tick_cnt = 0; end
      default: allowed_q = v[0];
    endcase
  endtask

  initial begin
    cob_id_q = 0; period_us_q = 0; allowed_q = 0; tick_cnt = 0;
    for (int i = 0; i < NTX; i++) begin tx_on[i] = 0; tx_kind[i] = 0; tx_cnt[i] = 0; end
    for (int i = 0; i < NRX; i++) begin
      rx_on[i] = 0; rx_id[i] = 0; rx_data[i] = 0; rx_dlc[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_SYNC_COB_ID, {2'b01, 1'b0, SYNC_A});
    write_reg(REG_CYCLE_PERIOD, 32'd250);
    write_reg(REG_SYNC_ALLOWED, 32'd1);

    // directed
    pending_items.push_back(mk(KIND_ADD, '0, 0, 0, 8'd0, 0, 0));
    pending_items.push_back(mk(KIND_ADD, '0, 0, 7, 8'd255, 0, 0));
    pending_items.push_back(mk(KIND_ADD, '0, 0, 3, 8'd2, 0, 0));
    pending_items.push_back(mk(KIND_ADD, 29'h1fffffff, 1, 7, 0, 0, 0));
    pending_items.push_back(mk(KIND_ADD, 29'd5, 1, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_ADD, 29'd5, 1, 2, 0, 0, 0));
    pending_items.push_back(mk(KIND_FRAME, 29'h1fffffff, 0, 0, 0, 4'd15, '1));
    pending_items.push_back(mk(KIND_FRAME, 29'd5, 0, 0, 0, 4'd8, 64'h0123456789abcdef));
    pending_items.push_back(mk(KIND_FRAME, 29'd6, 0, 0, 0, 4'd1, 64'h55));
    pending_items.push_back(mk(KIND_FRAME, SYNC_A, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_FRAME, SYNC_A, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_RESTART, '0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_FRAME, SYNC_A, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_ADD, 29'd9, 1, 7, 0, 0, 0));
    pending_items.push_back(mk(KIND_REMOVE, '0, 1, 2, 0, 0, 0));
    pending_items.push_back(mk(KIND_REMOVE, '0, 0, 3, 0, 0, 0));
    pending_items.push_back(mk(KIND_TICK, '0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_TICK, '0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(3'd5, '0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(3'd7, '0, 1, 7, 8'hff, 4'hf, '1));
    pending_items.push_back(mk(KIND_FRAME, SYNC_A, 0, 0, 0, 0, 0));
    wait_drained();

    // saturation of type-0 and type-255 counts
    for (int i = 0; i < 260; i++)
      pending_items.push_back(mk(KIND_FRAME, SYNC_A, 0, 0, 0, 0, 0));
    wait_drained();

    // random phases with several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin idle_pct = 0; write_reg(REG_CYCLE_PERIOD, 32'd100); end
        1: begin
          idle_pct = 48;
          write_reg(REG_SYNC_COB_ID, 32'hffffffff);
          write_reg(REG_CYCLE_PERIOD, 32'hffffffff);
        end
        2: begin
          idle_pct = 20;
          write_reg(REG_SYNC_COB_ID, {2'b01, 1'b0, 29'd3});
          write_reg(REG_CYCLE_PERIOD, 32'd399);
          write_reg(REG_SYNC_ALLOWED, 32'd0);
        end
        3: begin
          idle_pct = 48;
          write_reg(REG_SYNC_COB_ID, 32'd0);
          write_reg(REG_CYCLE_PERIOD, 32'd0);
          write_reg(REG_SYNC_ALLOWED, 32'd1);
        end
        4: begin
          idle_pct = 0;
          write_reg(REG_SYNC_COB_ID, {2'b01, 1'b0, 29'h1fffffff});
          write_reg(REG_CYCLE_PERIOD, 32'd99);
        end
        default: begin
          idle_pct = 20;
          write_reg(REG_SYNC_COB_ID, {2'b11, 1'b1, 29'd2});
          write_reg(REG_CYCLE_PERIOD, 32'd300);
        end
      endcase
      for (int i = 0; i < 15; i++) pending_items.push_back(rand_item(20));
      wait_drained();
    end

    idle_pct = 0;
    wait_drained();
    if (errors == 0) $display("[sync_event_pdo_scheduler] OK");
    else $display("[sync_event_pdo_scheduler] ERROR");
    $finish;
  end
endmodule

// File: sync_event_pdo_scheduler.f
+incdir+sv
sv/sesched_pkg.sv
sv/sesched_front.sv
sv/sesched_back.sv
sv/sync_event_pdo_scheduler.sv
dv/tb_top.sv
